// ----- hdl/hmp_pkg.sv -----
// Shared widths, constants and status codes of the hashed match model predictor.
package hmp_pkg;

  localparam int HIST_AW     = 16;
  localparam int HIST_DEPTH  = 1 << HIST_AW;
  localparam int SLOT_AW     = 16;
  localparam int SLOT_ENTRIES = 1 << SLOT_AW;
  localparam int BUCKET_AW   = 8;
  localparam int NUM_BUCKETS = 1 << BUCKET_AW;
  localparam int COUNT_BITS  = 16;
  localparam int POS_BITS    = 32;
  localparam int MAX_CONTEXT = 8;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 9;

  localparam logic [63:0] FNV_OFFSET = 64'hCBF29CE484222325;
  localparam logic [63:0] MIX_C1     = 64'hBF58476D1CE4E5B9;
  localparam logic [63:0] MIX_C2     = 64'h94D049BB133111EB;

  localparam logic [15:0] UNIFORM_Q16 = 16'd256;

  localparam logic [2:0] ST_SHORT   = 3'd0;
  localparam logic [2:0] ST_NO_CAND = 3'd1;
  localparam logic [2:0] ST_WINDOW  = 3'd2;
  localparam logic [2:0] ST_TOO_SHORT = 3'd3;
  localparam logic [2:0] ST_ACTIVE  = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_CONTEXT_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_MATCH      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BUCKET_COUNT   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HASH_BITS      = 2'd3;

endpackage

// ----- hdl/hmp_byte_if.sv -----
// Input channel: one stream byte per word.
interface hmp_byte_if import hmp_pkg::*;;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink (input valid, input byte_in, output ready);
endinterface

// ----- hdl/hmp_pred_if.sv -----
// Result channel: one prediction per word.
interface hmp_pred_if import hmp_pkg::*;;
  logic        valid;
  logic        ready;
  logic        pred_active;
  logic [7:0]  candidate_byte;
  logic [15:0] candidate_prob;
  logic [15:0] remainder_prob;
  logic [2:0]  match_status;
  logic [7:0]  match_len;
  logic [7:0]  bucket_index;

  modport source (output valid, output pred_active, output candidate_byte,
                  output candidate_prob, output remainder_prob, output match_status,
                  output match_len, output bucket_index, input ready);
  modport sink (input valid, input pred_active, input candidate_byte,
                input candidate_prob, input remainder_prob, input match_status,
                input match_len, input bucket_index, output ready);
endinterface

// ----- hdl/hmp_cfg_if.sv -----
// Configuration write channel: register index and data per word.
interface hmp_cfg_if import hmp_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- hdl/hashed_match_model_predictor_unit.sv -----
// Hashed match model byte predictor: history, slot table and counters in memories.
//
//  channel | dir | word
//  bytes   | in  | byte_in
//  preds   | out | pred_active, candidate_byte, candidate_prob, remainder_prob,
//          |     | match_status, match_len, bucket_index
//  cfg     | in  | index, data (always ready)
//
// One byte at a time. Each byte runs up to two context hashes, a match walk over up to
// 255 compared bytes and, when active, one 33-step serial division.
// After reset a clearing pass runs over the slot table and the counters before bytes are taken.
// A waiting result sits in the output register; the next byte is accepted meanwhile.
module hashed_match_model_predictor_unit import hmp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  hmp_byte_if.sink  bytes,
  hmp_pred_if.source preds,
  hmp_cfg_if.sink   cfg
);

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_SC_WR, S_ST_BEGIN, S_H_ISSUE, S_H_ACC, S_X_SH, S_X_M0, S_X_M1,
    S_X_M2, S_STORE, S_PR_BEGIN, S_SLOT_RD, S_SLOT_CHK, S_CAND_RD, S_CAND_GET, S_LEN,
    S_EVAL, S_DIV_LD, S_DIV_RUN, S_DIV_NEXT, S_FINISH
  } state_t;

  state_t state;
  logic [SLOT_AW-1:0] clr_idx;

  logic [3:0] ctx_len;
  logic [7:0] min_match;
  logic [8:0] bucket_count;
  logic [4:0] hash_bits;

  logic [HIST_AW-1:0]  wptr;
  logic [HIST_AW:0]    fill;
  logic [POS_BITS-1:0] pos;
  logic       pend_valid;
  logic [7:0] pend_sym;
  logic [7:0] pend_bucket;
  logic [7:0] byte_r;

  logic [63:0] h;
  logic [63:0] acc;
  logic [3:0]  hd;
  logic [1:0]  mix_step;
  logic        pass;
  logic        store_en;
  logic [SLOT_AW-1:0] slot;
  logic [HIST_AW:0]   d;
  logic [7:0]  len;
  logic [7:0]  r_cand;
  logic [15:0] r_cprob;
  logic [15:0] r_rprob;
  logic [2:0]  r_status;

  logic [32:0] dq;
  logic [16:0] rem;
  logic [16:0] den;
  logic [5:0]  dcnt;

  logic        o_valid;
  logic        o_active;
  logic [7:0]  o_cand;
  logic [15:0] o_cprob;
  logic [15:0] o_rprob;
  logic [2:0]  o_status;
  logic [7:0]  o_len;
  logic [7:0]  o_bucket;

  logic [7:0]  hist_mem [HIST_DEPTH];
  logic [32:0] slot_mem [SLOT_ENTRIES];
  logic [2*COUNT_BITS-1:0] cnt_mem [NUM_BUCKETS];
  logic [7:0]  rda;
  logic [7:0]  rdb;
  logic [32:0] sq;
  logic [2*COUNT_BITS-1:0] cq;

  logic [3:0]  ctx_eff;
  logic [4:0]  hb_eff;
  logic [15:0] hmask;
  logic [8:0]  bc_eff;
  logic [7:0]  maxlen;
  logic [7:0]  probe;
  logic [17:0] off;
  logic [HIST_AW-1:0] ra;
  logic [HIST_AW-1:0] rb;
  logic [63:0] fnv_x;
  logic [63:0] fnv_next;
  logic [63:0] mix_sh;
  logic [63:0] mix_c;
  logic [31:0] ma;
  logic [31:0] mb;
  logic [63:0] mp;
  logic [15:0] ch;
  logic [15:0] ct;
  logic [2*COUNT_BITS-1:0] cnt_upd;
  logic        slot_we;
  logic [SLOT_AW-1:0] slot_wa;
  logic [32:0] slot_wd;
  logic        cnt_we;
  logic [BUCKET_AW-1:0] cnt_wa;
  logic [2*COUNT_BITS-1:0] cnt_wd;
  logic [BUCKET_AW-1:0] cnt_ra;
  logic [17:0] dt;
  logic        dge;
  logic [16:0] rem_n;
  logic [16:0] share_num;
  logic [34:0] share_mul;
  logic [POS_BITS-1:0] cand_dist;
  logic        len_more;

  always_comb begin
    ctx_eff = (ctx_len == 4'd0) ? 4'd1 : (ctx_len > 4'(MAX_CONTEXT)) ? 4'(MAX_CONTEXT) : ctx_len;
    hb_eff  = (hash_bits == 5'd0) ? 5'd1 : (hash_bits > 5'd16) ? 5'd16 : hash_bits;
    hmask   = 16'((17'd1 << hb_eff) - 17'd1);
    bc_eff  = (bucket_count < 9'd2) ? 9'd2 : (bucket_count > 9'd256) ? 9'd256 : bucket_count;
    maxlen  = 8'(bc_eff - 9'd1);

    probe = (state == S_LEN) ? len + 8'd1 : 8'd0;
    off   = {1'b0, d} + 18'(probe) + 18'd1;
    case (state)
      S_H_ISSUE: ra = wptr - HIST_AW'(hd);
      S_CAND_RD: ra = wptr - d[HIST_AW-1:0];
      default:   ra = wptr - off[HIST_AW-1:0];
    endcase
    rb = wptr - (HIST_AW'(probe) + 16'd1);

    fnv_x    = h ^ {56'd0, rda};
    fnv_next = (fnv_x << 40) + (fnv_x * 64'd435);

    case (mix_step)
      2'd0:    mix_sh = h ^ (h >> 30);
      2'd1:    mix_sh = h ^ (h >> 27);
      default: mix_sh = h ^ (h >> 31);
    endcase
    mix_c = (mix_step == 2'd0) ? MIX_C1 : MIX_C2;
    case (state)
      S_X_M1:  begin ma = h[31:0];  mb = mix_c[63:32]; end
      S_X_M2:  begin ma = h[63:32]; mb = mix_c[31:0];  end
      default: begin ma = h[31:0];  mb = mix_c[31:0];  end
    endcase
    mp = ma * mb;

    ch = cq[2*COUNT_BITS-1:COUNT_BITS];
    ct = cq[COUNT_BITS-1:0];
    if (ct == 16'hFFFF) begin
      ch = (ch >> 1) + {15'd0, ch[0]};
      ct = (ct >> 1) + {15'd0, ct[0]};
    end
    ct = ct + 16'd1;
    if (byte_r == pend_sym) ch = ch + 16'd1;
    cnt_upd = {ch, ct};

    slot_we = (state == S_CLEAR) || (state == S_STORE && store_en);
    slot_wa = (state == S_CLEAR) ? clr_idx : slot;
    slot_wd = (state == S_CLEAR) ? 33'd0 : {1'b1, pos};
    cnt_we  = (state == S_CLEAR) || (state == S_SC_WR);
    cnt_wa  = (state == S_CLEAR) ? clr_idx[BUCKET_AW-1:0] : pend_bucket;
    cnt_wd  = (state == S_CLEAR) ? '0 : cnt_upd;
    cnt_ra  = (state == S_IDLE) ? pend_bucket : len;

    dt    = {rem, dq[32]};
    dge   = dt >= {1'b0, den};
    rem_n = dge ? 17'(dt - {1'b0, den}) : dt[16:0];

    // floor(x / 255) as (x * 131587) >> 25, exact for x up to 2^17
    share_num = 17'h10000 - {1'b0, dq[15:0]};
    share_mul = 35'(share_num) * 35'd131587;

    cand_dist = pos - sq[31:0];
    len_more  = ({1'b0, len} + 9'd1 < {1'b0, maxlen}) &&
                ({1'b0, d} + 18'(len) + 18'd2 <= {1'b0, fill});
  end

  always_ff @(posedge clk) begin
    if (state == S_STORE) hist_mem[wptr] <= byte_r;
    rda <= hist_mem[ra];
    rdb <= hist_mem[rb];
  end

  always_ff @(posedge clk) begin
    if (slot_we) slot_mem[slot_wa] <= slot_wd;
    sq <= slot_mem[slot];
  end

  always_ff @(posedge clk) begin
    if (cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
    cq <= cnt_mem[cnt_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctx_len      <= 4'd4;
      min_match    <= 8'd2;
      bucket_count <= 9'd32;
      hash_bits    <= 5'd16;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_CONTEXT_LENGTH: ctx_len      <= cfg.data[3:0];
        CFG_MIN_MATCH:      min_match    <= cfg.data[7:0];
        CFG_BUCKET_COUNT:   bucket_count <= cfg.data;
        CFG_HASH_BITS:      hash_bits    <= cfg.data[4:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_idx    <= '0;
      wptr       <= '0;
      fill       <= '0;
      pos        <= '0;
      pend_valid <= 1'b0;
      pend_sym   <= '0;
      pend_bucket <= '0;
      o_valid    <= 1'b0;
    end else begin
      if (preds.ready && state != S_FINISH) o_valid <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == '1) state <= S_IDLE;
        end
        S_IDLE: begin
          if (bytes.valid) begin
            byte_r     <= bytes.byte_in;
            pend_valid <= 1'b0;
            r_cand     <= '0;
            len        <= '0;
            r_cprob    <= UNIFORM_Q16;
            r_rprob    <= UNIFORM_Q16;
            state      <= pend_valid ? S_SC_WR : S_ST_BEGIN;
          end
        end
        S_SC_WR: state <= S_ST_BEGIN;
        S_ST_BEGIN: begin
          pass <= 1'b0;
          if (fill >= (HIST_AW+1)'(ctx_eff)) begin
            h     <= FNV_OFFSET;
            hd    <= ctx_eff;
            state <= S_H_ISSUE;
          end else begin
            store_en <= 1'b0;
            state    <= S_STORE;
          end
        end
        S_H_ISSUE: state <= S_H_ACC;
        S_H_ACC: begin
          h  <= fnv_next;
          hd <= hd - 4'd1;
          if (hd == 4'd1) begin
            mix_step <= 2'd0;
            state    <= S_X_SH;
          end else begin
            state <= S_H_ISSUE;
          end
        end
        S_X_SH: begin
          h <= mix_sh;
          if (mix_step == 2'd2) begin
            slot <= mix_sh[SLOT_AW-1:0] & hmask;
            if (pass) begin
              state <= S_SLOT_RD;
            end else begin
              store_en <= 1'b1;
              state    <= S_STORE;
            end
          end else begin
            state <= S_X_M0;
          end
        end
        S_X_M0: begin
          acc   <= mp;
          state <= S_X_M1;
        end
        S_X_M1: begin
          acc   <= acc + {mp[31:0], 32'd0};
          state <= S_X_M2;
        end
        S_X_M2: begin
          h        <= acc + {mp[31:0], 32'd0};
          mix_step <= mix_step + 2'd1;
          state    <= S_X_SH;
        end
        S_STORE: begin
          wptr  <= wptr + 1'b1;
          pos   <= pos + 1'b1;
          if (fill != (HIST_AW+1)'(HIST_DEPTH)) fill <= fill + 1'b1;
          state <= S_PR_BEGIN;
        end
        S_PR_BEGIN: begin
          if (fill < (HIST_AW+1)'(ctx_eff)) begin
            r_status <= ST_SHORT;
            state    <= S_FINISH;
          end else begin
            pass  <= 1'b1;
            h     <= FNV_OFFSET;
            hd    <= ctx_eff;
            state <= S_H_ISSUE;
          end
        end
        S_SLOT_RD: state <= S_SLOT_CHK;
        S_SLOT_CHK: begin
          if (!sq[32]) begin
            r_status <= ST_NO_CAND;
            state    <= S_FINISH;
          end else if (cand_dist == '0 || cand_dist > POS_BITS'(fill)) begin
            r_status <= ST_WINDOW;
            state    <= S_FINISH;
          end else begin
            d     <= cand_dist[HIST_AW:0];
            state <= S_CAND_RD;
          end
        end
        S_CAND_RD: state <= S_CAND_GET;
        S_CAND_GET: begin
          r_cand <= rda;
          state  <= ({1'b0, d} + 18'd1 <= {1'b0, fill}) ? S_LEN : S_EVAL;
        end
        S_LEN: begin
          if (rda == rdb) begin
            len   <= len + 8'd1;
            state <= len_more ? S_LEN : S_EVAL;
          end else begin
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (len < min_match) begin
            r_status <= ST_TOO_SHORT;
            state    <= S_FINISH;
          end else begin
            r_status <= ST_ACTIVE;
            state    <= S_DIV_LD;
          end
        end
        S_DIV_LD: begin
          dq      <= {17'(cq[2*COUNT_BITS-1:COUNT_BITS]) + 17'd1, 16'd0};
          den     <= 17'(cq[COUNT_BITS-1:0]) + 17'd2;
          rem     <= '0;
          dcnt    <= 6'd33;
          state   <= S_DIV_RUN;
        end
        S_DIV_RUN: begin
          rem  <= rem_n;
          dq   <= {dq[31:0], dge};
          dcnt <= dcnt - 6'd1;
          if (dcnt == 6'd1) state <= S_DIV_NEXT;
        end
        S_DIV_NEXT: begin
          r_cprob     <= dq[15:0];
          r_rprob     <= {6'd0, share_mul[34:25]};
          pend_valid  <= 1'b1;
          pend_sym    <= r_cand;
          pend_bucket <= len;
          state       <= S_FINISH;
        end
        S_FINISH: begin
          if (!o_valid || preds.ready) begin
            o_valid  <= 1'b1;
            o_active <= (r_status == ST_ACTIVE);
            o_cand   <= r_cand;
            o_cprob  <= r_cprob;
            o_rprob  <= r_rprob;
            o_status <= r_status;
            o_len    <= len;
            o_bucket <= (r_status == ST_ACTIVE) ? len : 8'd0;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign bytes.ready          = (state == S_IDLE);
  assign cfg.ready            = 1'b1;
  assign preds.valid          = o_valid;
  assign preds.pred_active    = o_active;
  assign preds.candidate_byte = o_cand;
  assign preds.candidate_prob = o_cprob;
  assign preds.remainder_prob = o_rprob;
  assign preds.match_status   = o_status;
  assign preds.match_len      = o_len;
  assign preds.bucket_index   = o_bucket;

endmodule

// ----- hdl/hmp_checker.sv -----
// Port-level checks on the result channel, bound to the top level.
module hmp_checker import hmp_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        valid,
  input logic        ready,
  input logic        pred_active,
  input logic [7:0]  candidate_byte,
  input logic [15:0] candidate_prob,
  input logic [15:0] remainder_prob,
  input logic [2:0]  match_status,
  input logic [7:0]  match_len,
  input logic [7:0]  bucket_index
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    valid && !ready |=> valid)
    else $error("result word dropped while stalled");

  a_active: assert property (@(posedge clk) disable iff (rst)
    valid |-> (pred_active == (match_status == ST_ACTIVE)))
    else $error("active flag disagrees with status");

  a_uniform: assert property (@(posedge clk) disable iff (rst)
    valid && !pred_active |-> candidate_prob == UNIFORM_Q16 &&
                              remainder_prob == UNIFORM_Q16 && bucket_index == 8'd0)
    else $error("inactive word not uniform");

  a_early: assert property (@(posedge clk) disable iff (rst)
    valid && (match_status == ST_SHORT || match_status == ST_NO_CAND ||
              match_status == ST_WINDOW) |-> match_len == 8'd0 && candidate_byte == 8'd0)
    else $error("length or candidate set without a candidate");

  a_bucket: assert property (@(posedge clk) disable iff (rst)
    valid && pred_active |-> bucket_index == match_len)
    else $error("bucket differs from match length");

endmodule

bind hashed_match_model_predictor_unit hmp_checker u_hmp_checker (
  .clk(clk),
  .rst(rst),
  .valid(preds.valid),
  .ready(preds.ready),
  .pred_active(preds.pred_active),
  .candidate_byte(preds.candidate_byte),
  .candidate_prob(preds.candidate_prob),
  .remainder_prob(preds.remainder_prob),
  .match_status(preds.match_status),
  .match_len(preds.match_len),
  .bucket_index(preds.bucket_index)
);
